/* sv/lfsa_pkg.sv */
package lfsa_pkg;

  // request operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // response status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NONE_FREE    = 2'd1;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [9:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [9:0] granted_slot;
    logic [1:0] status;
  } resp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_PRE,
    S_KTH,
    S_CHK,
    S_UPD
  } state_t;

endpackage

/* sv/lowest_free_slot_allocator.sv */
// channel   signals                 direction  handshake
// request   start, busy, request    in         taken on a clock edge with start high, busy low
// response  done, response          out        one-cycle strobe, cannot be held off
//
// an allocate reads the root, counts free slots below the index, descends to the
// lowest free one at or above it and updates the path, or ends after the count if
// none is free there; a release checks the leaf and updates the path, or ends after
// the check if the slot is free already; an index outside the pool is answered from idle;
// prefix count, descent and leaf-to-root update each walk one level a cycle; the receiver
// cannot stall the response; after reset a clearing pass loads every node; busy high
module lowest_free_slot_allocator import lfsa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  req_t  request,
  output logic  done,
  output resp_t response
);

  localparam int H  = $clog2(SLOTS);
  localparam int AW = H + 1;
  localparam int CW = $clog2(SLOTS + 1);

  // tree memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  // clearing sweep
  logic          init_done;
  logic          init_we;
  logic [AW-1:0] init_waddr;
  logic [CW-1:0] init_wdata;

  // sequencer
  logic          ctrl_idle;
  logic          ctrl_we;
  logic [AW-1:0] ctrl_waddr;
  logic [CW-1:0] ctrl_wdata;
  logic          fin;
  resp_t         resp;
  logic          go;

  assign busy = !init_done || !ctrl_idle;
  assign go   = start && !busy;

  lfsa_init #(.SLOTS(SLOTS)) u_init (
    .clk       (clk),
    .rst       (rst),
    .init_done (init_done),
    .we        (init_we),
    .waddr     (init_waddr),
    .wdata     (init_wdata)
  );

  lfsa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .req   (request),
    .idle  (ctrl_idle),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .we    (ctrl_we),
    .waddr (ctrl_waddr),
    .wdata (ctrl_wdata),
    .fin   (fin),
    .resp  (resp)
  );

  // the sweep owns the write port until the tree is loaded
  always_comb begin
    if (!init_done) begin
      ram_we    = init_we;
      ram_waddr = init_waddr;
      ram_wdata = init_wdata;
    end else begin
      ram_we    = ctrl_we;
      ram_waddr = ctrl_waddr;
      ram_wdata = ctrl_wdata;
    end
  end

  lfsa_tree_ram #(.AW(AW), .DW(CW)) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // response register, so the next request can be taken meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      response <= resp;
    end
  end

endmodule

/* sv/lfsa_tree_ram.sv */
module lfsa_tree_ram #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lfsa_init.sv */
module lfsa_init #(
  parameter int SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         init_done,
  output logic                         we,
  output logic [$clog2(SLOTS):0]       waddr,
  output logic [$clog2(SLOTS+1)-1:0]   wdata
);

  localparam int H  = $clog2(SLOTS);
  localparam int NW = H + 1;
  localparam int LW = $clog2(H + 1);
  localparam int CW = $clog2(SLOTS + 1);

  logic [LW-1:0] lvl;
  logic [H-1:0]  idx;
  logic [LW-1:0] down;
  logic [NW-1:0] span;
  logic [NW-1:0] first_leaf;
  logic [NW-1:0] size;
  logic [NW-1:0] remain;
  logic [NW-1:0] count;
  logic          last_in_level;

  // one node per cycle, level by level from the root
  always_comb begin
    down          = LW'(H) - lvl;
    span          = NW'(1) << lvl;
    last_in_level = ({1'b0, idx} == (span - NW'(1)));
    first_leaf    = {1'b0, idx} << down;
    size          = NW'(1) << down;
    remain        = NW'(SLOTS) - first_leaf;
    if (first_leaf >= NW'(SLOTS)) begin
      count = '0;
    end else if (remain < size) begin
      count = remain;
    end else begin
      count = size;
    end
  end

  assign we    = !init_done;
  assign waddr = span | {1'b0, idx};
  assign wdata = CW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
      lvl       <= '0;
      idx       <= '0;
    end else if (!init_done) begin
      if (last_in_level) begin
        idx <= '0;
        if (lvl == LW'(H)) begin
          init_done <= 1'b1;
        end else begin
          lvl <= lvl + LW'(1);
        end
      end else begin
        idx <= idx + H'(1);
      end
    end
  end

endmodule

/* sv/lfsa_ctrl.sv */
module lfsa_ctrl import lfsa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  req_t                         req,
  output logic                         idle,
  output logic [$clog2(SLOTS):0]       raddr,
  input  logic [$clog2(SLOTS+1)-1:0]   rdata,
  output logic                         we,
  output logic [$clog2(SLOTS):0]       waddr,
  output logic [$clog2(SLOTS+1)-1:0]   wdata,
  output logic                         fin,
  output resp_t                        resp
);

  localparam int H  = $clog2(SLOTS);
  localparam int AW = H + 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int QW = ((H > 10) ? H : 10) + 1;

  state_t        state, state_next;
  logic [AW-1:0] node, node_next;
  logic [H-1:0]  qsh, qsh_next;
  logic [CW-1:0] below, below_next;
  logic [CW-1:0] total, total_next;
  logic [CW-1:0] k, k_next;
  logic [QW-1:0] slot, slot_next;
  logic          rel, rel_next;

  logic [QW-1:0] q_wide;
  logic [CW-1:0] below_add;
  logic          go_right;
  logic [AW-1:0] child;

  assign q_wide = QW'(req.slot_index);
  assign idle   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    qsh   <= qsh_next;
    below <= below_next;
    total <= total_next;
    k     <= k_next;
    slot  <= slot_next;
    rel   <= rel_next;
  end

  always_comb begin
    state_next = state;
    node_next  = node;
    qsh_next   = qsh;
    below_next = below;
    total_next = total;
    k_next     = k;
    slot_next  = slot;
    rel_next   = rel;
    raddr      = node;
    we         = 1'b0;
    waddr      = node;
    wdata      = rel ? (rdata + CW'(1)) : (rdata - CW'(1));
    fin        = 1'b0;
    resp       = '{granted_slot: slot[9:0], status: ST_OK};
    below_add  = below;
    go_right   = 1'b0;
    child      = node;

    case (state)
      S_IDLE: begin
        if (go) begin
          rel_next   = (req.operation == OP_RELEASE);
          slot_next  = q_wide;
          qsh_next   = q_wide[H-1:0];
          below_next = '0;
          if (req.operation == OP_RELEASE) begin
            node_next = AW'(1 << H) | AW'(q_wide[H-1:0]);
            raddr     = AW'(1 << H) | AW'(q_wide[H-1:0]);
            if (q_wide >= QW'(SLOTS)) begin
              fin  = 1'b1;
              resp = '{granted_slot: req.slot_index, status: ST_ALREADY_FREE};
            end else begin
              state_next = S_CHK;
            end
          end else begin
            node_next = AW'(1);
            raddr     = AW'(1);
            if (q_wide >= QW'(SLOTS)) begin
              fin  = 1'b1;
              resp = '{granted_slot: 10'd0, status: ST_NONE_FREE};
            end else begin
              state_next = S_ROOT;
            end
          end
        end
      end

      S_ROOT: begin
        total_next = rdata;
        raddr      = {node[H-1:0], 1'b0};
        state_next = S_PRE;
      end

      // prefix count along the path of the start index
      S_PRE: begin
        go_right  = qsh[H-1];
        below_add = go_right ? (below + rdata) : below;
        child     = {node[H-1:0], go_right};
        qsh_next  = qsh << 1;
        if (child[H]) begin
          if (below_add >= total) begin
            fin        = 1'b1;
            resp       = '{granted_slot: 10'd0, status: ST_NONE_FREE};
            state_next = S_IDLE;
          end else begin
            k_next     = below_add + CW'(1);
            node_next  = AW'(1);
            raddr      = AW'(2);
            state_next = S_KTH;
          end
        end else begin
          below_next = below_add;
          node_next  = child;
          raddr      = {child[H-1:0], 1'b0};
        end
      end

      // descent to the k-th free leaf
      S_KTH: begin
        go_right  = (k > rdata);
        child     = {node[H-1:0], go_right};
        node_next = child;
        if (go_right) begin
          k_next = k - rdata;
        end
        if (child[H]) begin
          slot_next  = QW'(child[H-1:0]);
          raddr      = child;
          state_next = S_UPD;
        end else begin
          raddr = {child[H-1:0], 1'b0};
        end
      end

      S_CHK: begin
        if (rdata != '0) begin
          fin        = 1'b1;
          resp       = '{granted_slot: slot[9:0], status: ST_ALREADY_FREE};
          state_next = S_IDLE;
        end else begin
          raddr      = node;
          state_next = S_UPD;
        end
      end

      // leaf to root read-modify-write, one level a cycle
      S_UPD: begin
        we = 1'b1;
        if (node == AW'(1)) begin
          fin        = 1'b1;
          resp       = '{granted_slot: slot[9:0], status: ST_OK};
          state_next = S_IDLE;
        end else begin
          node_next = node >> 1;
          raddr     = node >> 1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* bench/lowest_free_slot_allocator_tb.sv */
`timescale 1ns / 100ps

module lowest_free_slot_allocator_tb;
  import lfsa_pkg::*;

  localparam int POOL            = 1024;
  localparam int RANDOM_REQUESTS = 750;
  // longest quiet spell: clearing pass after reset, else a sender gap plus
  // one allocate; taken several times over
  localparam int STALL_LIMIT     = 20000;
  // cycles left after the last response beat before the verdict
  localparam int SETTLE_CYCLES   = 40;

  // one queued request beat with its pacing
  typedef struct packed {
    req_t       req;
    logic [3:0] gap;    // idle cycles before start is raised
    logic       drain;  // hold off until every response is back
  } queued_req_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  start = 1'b0;
  logic  busy;
  req_t  request = '0;
  logic  done;
  resp_t response;

  queued_req_t queued_requests[$];
  resp_t       awaited_responses[$];

  // free map of the pool as the checker sees it
  bit          slot_free[POOL] = '{default: 1'b1};

  queued_req_t cur_req;
  logic        holding = 1'b0;
  logic [3:0]  gap_left = '0;
  logic        req_taken = 1'b0;
  logic        no_idle;
  int          fail_count = 0;
  int          idle_cycles = 0;

  lowest_free_slot_allocator #(
    .SLOTS(POOL)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .response(response)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected response for one request beat; updates the free map as the
  // block would: allocate takes the lowest free slot at or above the index,
  // release frees a used slot and flags a slot that is free already
  function automatic resp_t apply_pool_request(input req_t r);
    resp_t rsp;
    int    s;
    rsp.granted_slot = '0;
    rsp.status       = ST_OK;
    if (r.operation == OP_ALLOC) begin
      s = r.slot_index;
      while (s < POOL && !slot_free[s]) s++;
      if (s < POOL) begin
        slot_free[s]     = 1'b0;
        rsp.granted_slot = s[9:0];
      end else begin
        // nothing free up to the top of the pool: no change, slot reads 0
        rsp.status = ST_NONE_FREE;
      end
    end else begin
      // release echoes the index whatever happens
      rsp.granted_slot = r.slot_index;
      if (r.slot_index >= POOL || slot_free[r.slot_index]) begin
        rsp.status = ST_ALREADY_FREE;
      end else begin
        slot_free[r.slot_index] = 1'b1;
      end
    end
    return rsp;
  endfunction

  // queue one request beat; the gap is drawn here unless idling is off
  task automatic queue_request(input logic op, input logic [9:0] idx,
                               input logic drain);
    queued_req_t q;
    q.req.operation  = op;
    q.req.slot_index = idx;
    q.gap            = no_idle ? 4'd0 : 4'($urandom_range(0, 11));
    q.drain          = drain;
    queued_requests.push_back(q);
  endtask

  // driver: changes inputs on the falling edge only; start stays high
  // until the beat is taken, so it gets one assignment per step
  always @(negedge clk) begin : driver
    logic [31:0] filler;
    logic        go;
    filler = $urandom;
    go     = 1'b0;
    if (!rst) begin
      if (req_taken) holding = 1'b0;
      if (!holding && queued_requests.size() != 0) begin
        cur_req  = queued_requests.pop_front();
        gap_left = cur_req.gap;
        holding  = 1'b1;
      end
      if (holding) begin
        // a draining beat waits for the pipe to empty, then for its gap,
        // so the gap lands after the block has gone quiet
        if (!(cur_req.drain && awaited_responses.size() != 0)) begin
          if (gap_left != 0) gap_left--;
          else go = 1'b1;
        end
      end
    end
    start   <= go;
    // junk on the request bus while start is low
    request <= go ? cur_req.req : filler[$bits(req_t)-1:0];
  end

  // monitor: samples on the rising edge; a response beat is checked before
  // a request beat taken at the same edge is predicted
  always @(posedge clk) begin : monitor
    resp_t want;
    if (!rst) begin
      if (done) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t: response beat with none awaited: slot %0d status %0d",
                   $time, response.granted_slot, response.status);
          fail_count++;
        end else begin
          want = awaited_responses.pop_front();
          if (response.granted_slot !== want.granted_slot) begin
            $display("%0t: granted_slot mismatch: expected %0d, got %0d",
                     $time, want.granted_slot, response.granted_slot);
            fail_count++;
          end
          if (response.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, response.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) awaited_responses.push_back(apply_pool_request(request));
    end
    req_taken <= !rst && start && !busy;
  end

  // cycles with neither a request nor a response beat
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int         n;
    int         pick;
    int         s;
    int         k;
    logic       op;
    logic [9:0] idx;

    rst         = 1'b1;
    no_idle     = 1'b0;

    // directed: lowest slots, skipping over used ones
    queue_request(OP_ALLOC, 10'd0, 1'b0);
    queue_request(OP_ALLOC, 10'd0, 1'b0);
    queue_request(OP_ALLOC, 10'd1, 1'b0);
    // top slot, then nothing free at or above it
    queue_request(OP_ALLOC, 10'd1023, 1'b0);
    queue_request(OP_ALLOC, 10'd1023, 1'b1);
    queue_request(OP_ALLOC, 10'd1022, 1'b0);
    queue_request(OP_ALLOC, 10'd1020, 1'b0);
    queue_request(OP_ALLOC, 10'd1020, 1'b0);
    queue_request(OP_ALLOC, 10'd1020, 1'b0);
    // release used, then release of a slot already free
    queue_request(OP_RELEASE, 10'd1023, 1'b0);
    queue_request(OP_RELEASE, 10'd1023, 1'b0);
    queue_request(OP_ALLOC, 10'd1020, 1'b1);
    queue_request(OP_RELEASE, 10'd0, 1'b0);
    queue_request(OP_RELEASE, 10'd0, 1'b0);
    queue_request(OP_RELEASE, 10'd777, 1'b0);
    queue_request(OP_ALLOC, 10'd0, 1'b0);
    // around the middle of the tree
    queue_request(OP_ALLOC, 10'd512, 1'b0);
    queue_request(OP_ALLOC, 10'd511, 1'b0);
    queue_request(OP_ALLOC, 10'd511, 1'b0);
    queue_request(OP_RELEASE, 10'd1, 1'b1);
    queue_request(OP_ALLOC, 10'd0, 1'b0);
    // alternating index bits
    queue_request(OP_ALLOC, 10'd682, 1'b0);
    queue_request(OP_RELEASE, 10'd341, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // random: allocations biased to the bottom and to the top of the pool
    // (the top fills up and gives none-free answers), releases mostly of
    // slots in use, the rest at random indexes
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      while (queued_requests.size() >= 2) @(posedge clk);
      pick = $urandom_range(0, 99);
      op   = OP_ALLOC;
      if (pick < 20) begin
        idx = 10'($urandom_range(0, 31));
      end else if (pick < 40) begin
        idx = 10'($urandom_range(POOL - 24, POOL - 1));
      end else if (pick < 55) begin
        idx = 10'($urandom);
      end else begin
        op = OP_RELEASE;
        if (pick < 90) begin
          // first used slot from a random point, wrapping round
          s = $urandom_range(0, POOL - 1);
          for (k = 0; k < POOL && slot_free[s]; k++) s = (s + 1) % POOL;
          idx = s[9:0];
        end else begin
          idx = 10'($urandom);
        end
      end
      queue_request(op, idx, $urandom_range(0, 5) == 0);
    end

    while (queued_requests.size() != 0 || holding || awaited_responses.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* lowest_free_slot_allocator.f */
sv/lfsa_pkg.sv
sv/lfsa_tree_ram.sv
sv/lfsa_init.sv
sv/lfsa_ctrl.sv
sv/lowest_free_slot_allocator.sv
bench/lowest_free_slot_allocator_tb.sv
